/* rtl/assert_macros.svh */
// Assertion macros for the timer block checkers.
// Needs a clock and an active-high reset name at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check under reset gating
`define MST_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds through reset
`define MST_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mst_pkg.sv */
// Package for the multiplexed software timers: sizes, codes, types.
// No dependencies.
`timescale 1ns / 1ps
package mst_pkg;

  localparam int NUM_TIMERS  = 8;
  localparam int MAX_RESULTS = 8;
  localparam int ID_W        = 3;
  localparam int DW          = 32;
  localparam int TIDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int IDX_EXT_W   = (TIDX_W > ID_W) ? TIDX_W : ID_W;
  localparam int CNT_W       = $clog2(NUM_TIMERS + 1);
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_QUERY = 2'd3
  } action_t;

  typedef enum logic [0:0] {
    KIND_STATUS = 1'b0,
    KIND_EXPIRY = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_SCAN,
    ST_DECIDE,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic              set;
    logic              clr;
    logic [TIDX_W-1:0] idx;
    logic [DW-1:0]     deadline;
  } tf_ctrl_t;

endpackage

/* rtl/mst_if.sv */
// Stream interfaces for request and result beats of the timer block.
// Depends on mst_pkg.
`timescale 1ns / 1ps
interface mst_req_if import mst_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      action;
  logic [ID_W-1:0] timer_id;
  logic [DW-1:0]   duration;

  modport source (output valid, action, timer_id, duration, input ready);
  modport sink   (input valid, action, timer_id, duration, output ready);
endinterface

interface mst_rsp_if import mst_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            result_kind;
  logic [ID_W-1:0] which_timer;
  logic            refused;
  logic            ended;
  logic            last;

  modport source (output valid, result_kind, which_timer, refused, ended, last,
                  input ready);
  modport sink   (input valid, result_kind, which_timer, refused, ended, last,
                  output ready);
endinterface

/* rtl/multiplexed_software_timers.sv */
// Top level of the multiplexed software timers: sequencer, shared counter,
// scan comparator and result register. Depends on mst_pkg, mst_if, mst_timer_file.
//
//   channel  dir  handshake        payload
//   req      in   valid/ready      action, timer_id, duration
//   rsp      out  valid/ready      result_kind, which_timer, refused, ended, last
//   cfg      in   cfg_wr_en        cfg_wr_data (prescale)
//
// Start, stop and query hold the block in ST_CMD and ST_REPLY; ST_REPLY registers the beat.
// A tick with k expiries, k < MAX_RESULTS, runs k+1 passes of ST_SCAN and ST_DECIDE before
// its final beat is issued (none if k = 0); MAX_RESULTS expiries skip the closing pass.
// Each pass compares one deadline a cycle to find the earliest expiry.
// Reset is synchronous; no timer is active and the counter is zero afterwards.
// A stalled rsp holds the sequencer only when a further beat must leave.
`timescale 1ns / 1ps
module multiplexed_software_timers import mst_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  mst_req_if.sink       req,
  mst_rsp_if.source     rsp,
  input  logic          cfg_wr_en,
  input  logic [DW-1:0] cfg_wr_data
);

  state_t state, state_next;

  logic [DW-1:0]         prescale;
  logic [DW-1:0]         counter;
  logic [DW-1:0]         pcount;
  logic [DW-1:0]         counter_new;
  logic [DW-1:0]         pcount_new;

  action_t               act_q;
  logic [ID_W-1:0]       id_q;
  logic [DW-1:0]         dur_q;

  logic [TIDX_W-1:0]     scan_idx;
  logic [TIDX_W-1:0]     best_idx;
  logic [DW-1:0]         best_dl;
  logic                  none;
  logic [RES_W-1:0]      count;

  logic                  pend_v;
  logic                  pend_kind;
  logic [ID_W-1:0]       pend_id;
  logic                  pend_ref;
  logic                  pend_end;
  logic                  pend_last;

  tf_ctrl_t              tf_ctrl;
  logic [DW-1:0]         rd_dl;
  logic [NUM_TIMERS-1:0] active;
  logic [CNT_W-1:0]      total;
  logic                  emptied;

  logic [IDX_EXT_W-1:0]  id_ext;
  logic [TIDX_W-1:0]     id_idx;
  logic [IDX_EXT_W-1:0]  best_ext;
  logic                  id_valid;
  logic                  refused_c;
  logic                  hit;
  logic                  out_free;
  logic                  emit;
  logic                  take;

  mst_timer_file u_tf (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (tf_ctrl),
    .rd_idx      (scan_idx),
    .rd_deadline (rd_dl),
    .active      (active),
    .total       (total),
    .emptied     (emptied)
  );

  assign id_ext    = IDX_EXT_W'(id_q);
  assign id_idx    = id_ext[TIDX_W-1:0];
  assign best_ext  = IDX_EXT_W'(best_idx);
  assign id_valid  = 32'(id_q) < 32'(NUM_TIMERS);
  assign refused_c = !id_valid || (total == CNT_W'(NUM_TIMERS));
  assign out_free  = !rsp.valid || rsp.ready;
  assign hit       = active[scan_idx] && (none ? (rd_dl <= best_dl) : (rd_dl < best_dl));
  assign take      = !none && (!pend_v || out_free);

  always_comb begin
    if (pcount >= prescale) begin
      pcount_new  = '0;
      counter_new = counter + DW'(1);
    end else begin
      pcount_new  = pcount + DW'(1);
      counter_new = counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    tf_ctrl    = '0;
    emit       = 1'b0;
    req.ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = !rst;
        if (req.valid) state_next = ST_CMD;
      end
      ST_CMD: begin
        state_next = ST_REPLY;
        unique case (act_q)
          ACT_TICK: begin
            state_next = (total == '0) ? ST_IDLE : ST_SCAN;
          end
          ACT_START: begin
            if (!refused_c) begin
              tf_ctrl.set      = 1'b1;
              tf_ctrl.idx      = id_idx;
              tf_ctrl.deadline = counter + dur_q;
            end
          end
          ACT_STOP: begin
            if (id_valid) begin
              tf_ctrl.clr = 1'b1;
              tf_ctrl.idx = id_idx;
            end
          end
          ACT_QUERY: begin
          end
        endcase
      end
      ST_SCAN: begin
        if (scan_idx == TIDX_W'(NUM_TIMERS - 1)) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (none) begin
          state_next = pend_v ? ST_REPLY : ST_IDLE;
        end else if (take) begin
          tf_ctrl.clr = 1'b1;
          tf_ctrl.idx = best_idx;
          emit        = pend_v;
          state_next  = (count == RES_W'(MAX_RESULTS - 1)) ? ST_REPLY : ST_SCAN;
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      act_q <= action_t'(req.action);
      id_q  <= req.timer_id;
      dur_q <= req.duration;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale <= '0;
      counter  <= '0;
      pcount   <= '0;
      pend_v   <= 1'b0;
      count    <= '0;
      none     <= 1'b1;
      scan_idx <= '0;
    end else begin
      if (cfg_wr_en) prescale <= cfg_wr_data;
      unique case (state)
        ST_CMD: begin
          if (act_q == ACT_TICK) begin
            if (total != '0) begin
              pcount   <= pcount_new;
              counter  <= counter_new;
              best_dl  <= counter_new;
              scan_idx <= '0;
              none     <= 1'b1;
              count    <= '0;
              pend_v   <= 1'b0;
            end
          end else begin
            pend_v    <= 1'b1;
            pend_kind <= KIND_STATUS;
            pend_id   <= id_q;
            pend_ref  <= (act_q == ACT_START) && refused_c;
            pend_end  <= (act_q == ACT_QUERY) && !(id_valid && active[id_idx]);
            pend_last <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (hit) begin
            none     <= 1'b0;
            best_idx <= scan_idx;
            best_dl  <= rd_dl;
          end
          if (scan_idx == TIDX_W'(NUM_TIMERS - 1)) scan_idx <= '0;
          else                                     scan_idx <= scan_idx + TIDX_W'(1);
        end
        ST_DECIDE: begin
          if (none) begin
            pend_last <= 1'b1;
          end else if (take) begin
            pend_v    <= 1'b1;
            pend_kind <= KIND_EXPIRY;
            pend_id   <= best_ext[ID_W-1:0];
            pend_ref  <= 1'b0;
            pend_end  <= 1'b0;
            pend_last <= (count == RES_W'(MAX_RESULTS - 1));
            count     <= count + RES_W'(1);
            scan_idx  <= '0;
            none      <= 1'b1;
            best_dl   <= counter;
          end
        end
        ST_REPLY: begin
          if (out_free) pend_v <= 1'b0;
        end
        ST_IDLE: begin
        end
        default: begin
        end
      endcase
      if (emptied) begin
        counter <= '0;
        pcount  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (emit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.result_kind <= pend_kind;
      rsp.which_timer <= pend_id;
      rsp.refused     <= pend_ref;
      rsp.ended       <= pend_end;
      rsp.last        <= pend_last;
    end
  end

endmodule

/* rtl/mst_timer_file.sv */
// Timer file: active flags, deadline registers and the active count.
// Depends on mst_pkg.
`timescale 1ns / 1ps
module mst_timer_file import mst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  tf_ctrl_t              ctrl,
  input  logic [TIDX_W-1:0]     rd_idx,
  output logic [DW-1:0]         rd_deadline,
  output logic [NUM_TIMERS-1:0] active,
  output logic [CNT_W-1:0]      total,
  output logic                  emptied
);

  logic [DW-1:0] deadlines [NUM_TIMERS];

  assign rd_deadline = deadlines[rd_idx];
  assign emptied = ctrl.clr && active[ctrl.idx] && (total == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      total  <= '0;
    end else if (ctrl.set) begin
      active[ctrl.idx] <= 1'b1;
      if (!active[ctrl.idx]) total <= total + CNT_W'(1);
    end else if (ctrl.clr && active[ctrl.idx]) begin
      active[ctrl.idx] <= 1'b0;
      total <= total - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.set) deadlines[ctrl.idx] <= ctrl.deadline;
  end

endmodule

/* rtl/mst_checker.sv */
// Port-level checker for the multiplexed software timers, with its bind.
// Depends on mst_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mst_checker import mst_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input logic            rsp_kind,
  input logic [ID_W-1:0] rsp_timer,
  input logic            rsp_refused,
  input logic            rsp_ended,
  input logic            rsp_last
);

  logic            rsp_stall;
  logic            rsp_exp;
  logic [ID_W+3:0] rsp_beat;

  assign rsp_stall = rsp_valid && !rsp_ready;
  assign rsp_exp   = rsp_valid && rsp_kind;
  assign rsp_beat  = {rsp_kind, rsp_timer, rsp_refused, rsp_ended, rsp_last};

  `MST_ASSERT(a_rsp_hold, clk, rst, rsp_stall |=> rsp_valid && $stable(rsp_beat), "beat dropped")
  `MST_ASSERT(a_req_busy, clk, rst, req_valid && req_ready |=> !req_ready, "req taken while busy")
  `MST_ASSERT(a_status_last, clk, rst, rsp_valid && !rsp_kind |-> rsp_last, "status not last")
  `MST_ASSERT(a_expiry_flags, clk, rst, rsp_exp |-> !rsp_refused && !rsp_ended, "flags on expiry")
  `MST_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> !rsp_valid, "rsp valid after reset")

endmodule

bind multiplexed_software_timers mst_checker u_mst_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_kind    (rsp.result_kind),
  .rsp_timer   (rsp.which_timer),
  .rsp_refused (rsp.refused),
  .rsp_ended   (rsp.ended),
  .rsp_last    (rsp.last)
);
